// ===== rtl/weighted_sparse_slot_sampler_unit_assert.svh =====
// Assertion macros for the slot sampler.
`ifndef WEIGHTED_SPARSE_SLOT_SAMPLER_UNIT_ASSERT_SVH
`define WEIGHTED_SPARSE_SLOT_SAMPLER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define WSS_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define WSS_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define WSS_ASSERT_IMP(label, clk, rst_n, a, b)
`define WSS_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/wss_pkg.sv =====
// Package: shared types and constants of the slot sampler.
`default_nettype none
package wss_pkg;
    localparam int DIM_ENTRIES_DEF = 4096;
    localparam int MAX_SLOTS_DEF = 40;
    localparam int CNT_W = 7;

    localparam logic [1:0] FUNC_MEASURE = 2'd0;
    localparam logic [1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [1:0] FUNC_LOAD = 2'd2;
    localparam logic [1:0] FUNC_RESERVED = 2'd3;

    localparam logic [2:0] REG_USE_WEIGHTS = 3'd0;
    localparam logic [2:0] REG_USE_TABLES = 3'd1;
    localparam logic [2:0] REG_FIXED_LENGTH = 3'd2;
    localparam logic [2:0] REG_ACTIVE_DIMS = 3'd3;
    localparam logic [2:0] REG_SLOT_LIMIT = 3'd4;

    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;
    localparam logic [23:0] PROB_ONE = 24'h800000;
    localparam logic [31:0] DEFAULT_MAX = 32'd65536;

    typedef struct packed {
        logic [1:0]  func;
        logic        first;
        logic        last;
        logic        in_range;
        logic [31:0] seed;
        logic [11:0] idx;
        logic [31:0] value;
        logic [23:0] weight;
        logic [5:0]  length;
        logic [17:0] start;
    } entry_t;

    typedef struct packed {
        logic        use_weights;
        logic        use_tables;
        logic [7:0]  fixed_length;
        logic [19:0] slot_limit;
    } cfg_t;

    typedef struct packed {
        logic [19:0] slot;
        logic        slot_valid;
        logic        item_end;
        logic        row_end;
        logic [15:0] set_size;
    } res_t;
endpackage
`default_nettype wire

// ===== rtl/wss_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module wss_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  wire logic                                  clk,
    input  wire logic                                  wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/wss_front.sv =====
// Front end: accepts items, classifies them and queues them for the back end.
`default_nettype none
module wss_front #(
    parameter int DIM_ENTRIES = wss_pkg::DIM_ENTRIES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [1:0]    func,
    input  wire logic          row_first,
    input  wire logic          row_last,
    input  wire logic [15:0]   group_id,
    input  wire logic [23:0]   point_number,
    input  wire logic [11:0]   dim_index,
    input  wire logic [31:0]   sample_value,
    input  wire logic [23:0]   entry_weight,
    input  wire logic [5:0]    entry_length,
    input  wire logic [17:0]   entry_start,
    input  wire logic [12:0]   active_dims,
    output wss_pkg::entry_t    q_head,
    output logic               q_valid,
    input  wire logic          q_pop
);
    wss_pkg::entry_t q_mem [2];
    wss_pkg::entry_t entry;
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            accept;
    logic [31:0]     seed_g;
    logic [31:0]     seed_p;

    assign full = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_head = q_mem[rd_ptr_reg];
    assign accept = push && !full;

    always_comb
    begin
        seed_g = 32'(group_id) * 32'd10007;
        seed_p = 32'(point_number) * 32'd12345;
        entry.func = func;
        entry.first = row_first;
        entry.last = row_last;
        entry.in_range = ({5'd0, dim_index} < 17'(DIM_ENTRIES)) &&
                         ((active_dims == 13'd0) || ({1'b0, dim_index} < active_dims));
        entry.seed = seed_g + seed_p + 32'd1354;
        entry.idx = dim_index;
        entry.value = sample_value;
        entry.weight = entry_weight;
        entry.length = entry_length;
        entry.start = entry_start;
        wr_ptr_next = accept ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + 2'(accept) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/wss_back.sv =====
// Back end: row maximum, table store, division, weighting, slot draws, result queue.
`default_nettype none
`include "weighted_sparse_slot_sampler_unit_assert.svh"
module wss_back #(
    parameter int DIM_ENTRIES = wss_pkg::DIM_ENTRIES_DEF,
    parameter int MAX_SLOTS_PER_DIM = wss_pkg::MAX_SLOTS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire wss_pkg::entry_t q_head,
    input  wire logic         q_valid,
    output logic              q_pop,
    input  wire wss_pkg::cfg_t cfg,
    output wss_pkg::res_t     res_head,
    output logic              res_valid,
    input  wire logic         res_pop
);
    localparam int AW = DIM_ENTRIES > 1 ? $clog2(DIM_ENTRIES) : 1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DIV    = 7'b0000010,
        S_MUL    = 7'b0000100,
        S_SETUP  = 7'b0001000,
        S_BOUND  = 7'b0010000,
        S_DRAW   = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [31:0]         max_reg, max_next;
    logic [31:0]         gen_reg, gen_next;
    logic [15:0]         count_reg, count_next;
    logic [11:0]         idx_reg, idx_next;
    logic                last_reg, last_next;
    logic [32:0]         rem_reg, rem_next;
    logic [31:0]         den_reg, den_next;
    logic [4:0]          step_reg, step_next;
    logic [23:0]         p_reg, p_next;
    logic [47:0]         prod_reg, prod_next;
    logic [7:0]          len_reg, len_next;
    logic [19:0]         start_reg, start_next;
    logic [19:0]         s_reg, s_next;
    logic [wss_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [19:0]         pend_slot_reg, pend_slot_next;

    logic [47:0]         ram_rd;
    logic                ram_wr, ram_re;
    logic [32:0]         rem_sh;
    logic [31:0]         draw_state;
    logic                emit;
    logic [31:0]         scaled;
    logic [7:0]          flen;
    logic [20:0]         upper;
    logic [19:0]         limit, upper_c;
    logic [19:0]         span;
    logic                rq_push;
    wss_pkg::res_t       rq_data;
    wss_pkg::res_t       rq_mem [2];
    logic                rq_wr_reg, rq_rd_reg;
    logic [1:0]          rq_cnt_reg;
    logic                rq_full;

    assign rq_full = (rq_cnt_reg == 2'd2);
    assign res_valid = (rq_cnt_reg != 2'd0);
    assign res_head = rq_mem[rq_rd_reg];

    assign ram_wr = q_pop && (q_head.func == wss_pkg::FUNC_LOAD) &&
                    ({5'd0, q_head.idx} < 17'(DIM_ENTRIES));
    assign ram_re = q_pop && (q_head.func == wss_pkg::FUNC_SAMPLE);

    wss_ram #(
        .WIDTH(48),
        .DEPTH(DIM_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (AW'(q_head.idx)),
        .wr_data ({q_head.weight, q_head.length, q_head.start}),
        .rd_en   (ram_re),
        .rd_addr (AW'(q_head.idx)),
        .rd_data (ram_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        max_next = max_reg;
        gen_next = gen_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        last_next = last_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        step_next = step_reg;
        p_next = p_reg;
        prod_next = prod_reg;
        len_next = len_reg;
        start_next = start_reg;
        s_next = s_reg;
        cnt_next = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next = pend_slot_reg;
        q_pop = 1'b0;
        rq_push = 1'b0;
        rq_data = '0;
        rem_sh = {rem_reg[31:0], 1'b0};
        draw_state = gen_reg * wss_pkg::LCG_MUL + wss_pkg::LCG_ADD;
        emit = ({1'b0, draw_state[22:0]} < p_reg);
        scaled = prod_reg[47:16];
        flen = (cfg.fixed_length < 8'd3) ? 8'd3 : cfg.fixed_length;
        limit = (cfg.slot_limit < 20'd2) ? 20'd2 : cfg.slot_limit;
        upper = {1'b0, start_reg} + 21'(len_reg);
        upper_c = (upper > {1'b0, limit}) ? limit : upper[19:0];
        span = (upper_c > start_reg) ? (upper_c - start_reg) : 20'd0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_head.func)
                        wss_pkg::FUNC_MEASURE:
                        begin
                            if (q_head.first)
                            begin
                                max_next = (q_head.value[31] || q_head.value == 32'd0) ?
                                           32'd0 : q_head.value;
                            end
                            else if ($signed(q_head.value) > $signed(max_reg))
                            begin
                                max_next = q_head.value;
                            end
                        end
                        wss_pkg::FUNC_SAMPLE:
                        begin
                            if (q_head.first)
                            begin
                                gen_next = q_head.seed;
                                count_next = 16'd0;
                            end
                            idx_next = q_head.idx;
                            last_next = q_head.last;
                            pend_valid_next = 1'b0;
                            den_next = ($signed(max_reg) > 0) ? max_reg : wss_pkg::DEFAULT_MAX;
                            rem_next = {1'b0, q_head.value};
                            step_next = 5'd0;
                            p_next = 24'd0;
                            if (q_head.value[31] || q_head.value == 32'd0 || !q_head.in_range)
                            begin
                                state_next = S_FINISH;
                            end
                            else if (q_head.value >= den_next)
                            begin
                                p_next = wss_pkg::PROB_ONE;
                                state_next = S_MUL;
                            end
                            else
                            begin
                                state_next = S_DIV;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = rem_sh - {1'b0, den_reg};
                    p_next = {p_reg[22:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    p_next = {p_reg[22:0], 1'b0};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd22)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next = p_reg * ram_rd[47:24];
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                if (cfg.use_weights)
                begin
                    p_next = (scaled > 32'(wss_pkg::PROB_ONE)) ? wss_pkg::PROB_ONE :
                             scaled[23:0];
                end
                if (cfg.use_tables)
                begin
                    len_next = {2'd0, ram_rd[23:18]};
                    start_next = {2'd0, ram_rd[17:0]};
                end
                else
                begin
                    len_next = flen;
                    start_next = {8'd0, idx_reg} * {12'd0, flen};
                end
                state_next = S_BOUND;
            end
            S_BOUND:
            begin
                s_next = start_reg;
                cnt_next = (span > 20'(MAX_SLOTS_PER_DIM)) ?
                           wss_pkg::CNT_W'(MAX_SLOTS_PER_DIM) : span[wss_pkg::CNT_W-1:0];
                if (p_reg == 24'd0 || span == 20'd0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_DRAW;
                end
            end
            S_DRAW:
            begin
                if (!rq_full)
                begin
                    gen_next = draw_state;
                    if (emit)
                    begin
                        if (pend_valid_reg)
                        begin
                            rq_push = 1'b1;
                            rq_data.slot = pend_slot_reg;
                            rq_data.slot_valid = 1'b1;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next = s_reg;
                        if (count_reg != 16'hFFFF)
                        begin
                            count_next = count_reg + 16'd1;
                        end
                    end
                    s_next = s_reg + 20'd1;
                    cnt_next = cnt_reg - wss_pkg::CNT_W'(1);
                    if (cnt_reg == wss_pkg::CNT_W'(1))
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (!rq_full)
                begin
                    rq_push = 1'b1;
                    rq_data.slot = pend_valid_reg ? pend_slot_reg : 20'd0;
                    rq_data.slot_valid = pend_valid_reg;
                    rq_data.item_end = 1'b1;
                    rq_data.row_end = last_reg;
                    rq_data.set_size = last_reg ? count_reg : 16'd0;
                    pend_valid_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rq_push)
        begin
            rq_mem[rq_wr_reg] <= rq_data;
        end
        idx_reg <= idx_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        step_reg <= step_next;
        p_reg <= p_next;
        prod_reg <= prod_next;
        len_reg <= len_next;
        start_reg <= start_next;
        s_reg <= s_next;
        cnt_reg <= cnt_next;
        pend_slot_reg <= pend_slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            max_reg <= 32'd0;
            gen_reg <= 32'd0;
            count_reg <= 16'd0;
            last_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            rq_wr_reg <= 1'b0;
            rq_rd_reg <= 1'b0;
            rq_cnt_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            max_reg <= max_next;
            gen_reg <= gen_next;
            count_reg <= count_next;
            last_reg <= last_next;
            pend_valid_reg <= pend_valid_next;
            rq_wr_reg <= rq_push ? !rq_wr_reg : rq_wr_reg;
            rq_rd_reg <= res_pop ? !rq_rd_reg : rq_rd_reg;
            rq_cnt_reg <= rq_cnt_reg + 2'(rq_push) - 2'(res_pop);
        end
    end

    `WSS_ASSERT_IMP(a_state_onehot, clk, rst_n, 1'b1, $onehot(state_reg))
    `WSS_ASSERT_IMP(a_no_push_full, clk, rst_n, rq_push, !rq_full)
    `WSS_ASSERT_IMP(a_draw_prob, clk, rst_n, state_reg == S_DRAW, p_reg != 24'd0)
    `WSS_ASSERT_NXT(a_finish_done, clk, rst_n, state_reg == S_FINISH && !rq_full,
                    state_reg == S_IDLE && !pend_valid_reg)
endmodule
`default_nettype wire

// ===== rtl/weighted_sparse_slot_sampler_unit.sv =====
// Top level of the weighted sparse slot sampler.
//
// channel   direction  handshake
// input     in         push / full
// result    out        pop / empty
// config    in         psel, penable, pwrite, pready (APB)
//
// Measure and table-load items are consumed in the idle state. A sample item goes
// straight to finish when skipped; else the 23-step restoring divider may run,
// then one candidate slot is tested per cycle, up to MAX_SLOTS_PER_DIM.
// The back end stalls drawing while the two-entry result queue is full.
// Reset is asynchronous; table contents are not cleared.
`default_nettype none
module weighted_sparse_slot_sampler_unit #(
    parameter int DIM_ENTRIES = wss_pkg::DIM_ENTRIES_DEF,
    parameter int MAX_SLOTS_PER_DIM = wss_pkg::MAX_SLOTS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [1:0]   func,
    input  wire logic         row_first,
    input  wire logic         row_last,
    input  wire logic [15:0]  group_id,
    input  wire logic [23:0]  point_number,
    input  wire logic [11:0]  dim_index,
    input  wire logic [31:0]  sample_value,
    input  wire logic [23:0]  entry_weight,
    input  wire logic [5:0]   entry_length,
    input  wire logic [17:0]  entry_start,
    input  wire logic         pop,
    output logic              empty,
    output logic [19:0]       slot,
    output logic              slot_valid,
    output logic              item_end,
    output logic              row_end,
    output logic [15:0]       set_size,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    wss_pkg::entry_t q_head;
    logic            q_valid, q_pop;
    wss_pkg::cfg_t   cfg;
    wss_pkg::res_t   res_head;
    logic            res_valid, res_pop;
    logic            use_weights_reg;
    logic            use_tables_reg;
    logic [7:0]      fixed_length_reg;
    logic [12:0]     active_dims_reg;
    logic [19:0]     slot_limit_reg;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign cfg = '{use_weights: use_weights_reg, use_tables: use_tables_reg,
                   fixed_length: fixed_length_reg, slot_limit: slot_limit_reg};
    assign empty = !res_valid;
    assign res_pop = pop && res_valid;
    assign slot = res_head.slot;
    assign slot_valid = res_head.slot_valid;
    assign item_end = res_head.item_end;
    assign row_end = res_head.row_end;
    assign set_size = res_head.set_size;

    always_comb
    begin
        case (paddr[4:2])
            wss_pkg::REG_USE_WEIGHTS:  prdata = {31'd0, use_weights_reg};
            wss_pkg::REG_USE_TABLES:   prdata = {31'd0, use_tables_reg};
            wss_pkg::REG_FIXED_LENGTH: prdata = {24'd0, fixed_length_reg};
            wss_pkg::REG_ACTIVE_DIMS:  prdata = {19'd0, active_dims_reg};
            wss_pkg::REG_SLOT_LIMIT:   prdata = {12'd0, slot_limit_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_weights_reg <= 1'b1;
            use_tables_reg <= 1'b1;
            fixed_length_reg <= 8'd3;
            active_dims_reg <= 13'd4096;
            slot_limit_reg <= 20'd163841;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                wss_pkg::REG_USE_WEIGHTS:  use_weights_reg <= pwdata[0];
                wss_pkg::REG_USE_TABLES:   use_tables_reg <= pwdata[0];
                wss_pkg::REG_FIXED_LENGTH: fixed_length_reg <= pwdata[7:0];
                wss_pkg::REG_ACTIVE_DIMS:  active_dims_reg <= pwdata[12:0];
                wss_pkg::REG_SLOT_LIMIT:   slot_limit_reg <= pwdata[19:0];
                default:
                begin
                end
            endcase
        end
    end

    wss_front #(
        .DIM_ENTRIES(DIM_ENTRIES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .func         (func),
        .row_first    (row_first),
        .row_last     (row_last),
        .group_id     (group_id),
        .point_number (point_number),
        .dim_index    (dim_index),
        .sample_value (sample_value),
        .entry_weight (entry_weight),
        .entry_length (entry_length),
        .entry_start  (entry_start),
        .active_dims  (active_dims_reg),
        .q_head       (q_head),
        .q_valid      (q_valid),
        .q_pop        (q_pop)
    );

    wss_back #(
        .DIM_ENTRIES       (DIM_ENTRIES),
        .MAX_SLOTS_PER_DIM (MAX_SLOTS_PER_DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .cfg       (cfg),
        .res_head  (res_head),
        .res_valid (res_valid),
        .res_pop   (res_pop)
    );
endmodule
`default_nettype wire
